// ===== rtl/core/obuhp_pkg.sv =====
// ----------------------------------------------------------------------------
// obuhp_pkg
// Shared types and constants for the OBU header parser.
// ----------------------------------------------------------------------------
package obuhp_pkg;

  localparam int MAX_SIZE_BYTES = 8;
  localparam int SIZE_W         = 56;
  localparam int LEFT_W         = 32;
  localparam int IDX_W          = 3;
  localparam int TYPE_W         = 4;
  localparam int LEB_BITS       = 7;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORBIDDEN = 3'd1,
    ST_RESERVED  = 3'd2,
    ST_EXTENSION = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  typedef struct packed {
    logic              in_size_field;
    logic [SIZE_W-1:0] size_accum;
    logic [IDX_W-1:0]  size_byte_index;
    logic [TYPE_W-1:0] held_type;
  } parse_state_t;

  typedef struct packed {
    status_t           status;
    logic [TYPE_W-1:0] obu_type;
    logic              size_present;
    logic [SIZE_W-1:0] obu_size;
  } result_t;

endpackage

// ===== rtl/core/obuhp_step.sv =====
// ----------------------------------------------------------------------------
// obuhp_step
// One parse step: header checks or one LEB128 size byte, next state and result.
// ----------------------------------------------------------------------------
module obuhp_step (
  input  obuhp_pkg::parse_state_t              state,
  input  logic [7:0]                           data_byte,
  input  logic [obuhp_pkg::LEFT_W-1:0]         bytes_after,
  output obuhp_pkg::parse_state_t              state_next,
  output logic                                 emit,
  output obuhp_pkg::result_t                   result
);
  import obuhp_pkg::*;

  logic              forbidden;
  logic [TYPE_W-1:0] hdr_type;
  logic              ext;
  logic              size_flag;
  logic              left_zero;
  logic              last;
  logic [5:0]        shamt;
  logic [SIZE_W-1:0] accum_new;
  logic [SIZE_W-1:0] left_ext;

  assign forbidden = data_byte[7];
  assign hdr_type  = data_byte[6:3];
  assign ext       = data_byte[2];
  assign size_flag = data_byte[1];
  assign left_zero = (bytes_after == '0);
  assign left_ext  = SIZE_W'(bytes_after);

  // LEB128 groups land at 7 * index
  assign shamt     = {state.size_byte_index, 3'b000} - 6'(state.size_byte_index);
  assign accum_new = state.size_accum | (SIZE_W'(data_byte[6:0]) << shamt);
  assign last      = (state.size_byte_index == IDX_W'(MAX_SIZE_BYTES - 1)) || !data_byte[7];

  always_comb begin
    state_next                 = state;
    state_next.in_size_field   = 1'b0;
    state_next.size_accum      = '0;
    state_next.size_byte_index = '0;
    emit                       = 1'b1;
    result.status              = ST_OK;
    result.obu_type            = state.held_type;
    result.size_present        = 1'b1;
    result.obu_size            = '0;
    if (!state.in_size_field) begin
      state_next.held_type = hdr_type;
      result.obu_type      = hdr_type;
      result.size_present  = size_flag;
      if (forbidden) begin
        result.status = ST_FORBIDDEN;
      end else if (hdr_type == '0) begin
        result.status = ST_RESERVED;
      end else if (ext) begin
        result.status = ST_EXTENSION;
      end else if (!size_flag) begin
        result.obu_size = left_ext;
      end else if (left_zero) begin
        result.status = ST_TRUNCATED;
      end else begin
        emit                     = 1'b0;
        state_next.in_size_field = 1'b1;
      end
    end else begin
      if (last) begin
        if (accum_new > left_ext) begin
          result.status = ST_TOO_LARGE;
        end else begin
          result.obu_size = accum_new;
        end
      end else if (left_zero) begin
        result.status = ST_TRUNCATED;
      end else begin
        emit                       = 1'b0;
        state_next.in_size_field   = 1'b1;
        state_next.size_accum      = accum_new;
        state_next.size_byte_index = state.size_byte_index + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/obu_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// obu_header_parser_core
// Byte-serial AV1 OBU header and LEB128 size parser.
// ----------------------------------------------------------------------------
// One byte beat is taken per cycle while in_ready is high. Each beat is
// registered, parsed against the parse state once the output register can
// take a result, and any result is registered for the output. At most one
// result per beat; header and size bytes that need more input give none.
// in_ready follows out_ready combinationally through the two stages.
module obu_header_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic [obuhp_pkg::LEFT_W-1:0]  bytes_after,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [obuhp_pkg::TYPE_W-1:0]  obu_type,
  output logic                          size_present,
  output logic [obuhp_pkg::SIZE_W-1:0]  obu_size
);
  import obuhp_pkg::*;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [LEFT_W-1:0] s1_left;
  logic              s1_fire;
  parse_state_t      state;
  parse_state_t      state_next;
  logic              emit;
  result_t           result;
  result_t           out_reg;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  obuhp_step u_step (
    .state       (state),
    .data_byte   (s1_byte),
    .bytes_after (s1_left),
    .state_next  (state_next),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_left <= bytes_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && emit) begin
      out_reg <= result;
    end
  end

  assign status       = out_reg.status;
  assign obu_type     = out_reg.obu_type;
  assign size_present = out_reg.size_present;
  assign obu_size     = out_reg.obu_size;

endmodule

// ===== tb/obu_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obu_parse_checker
// Watches both channels of the OBU header parser, works out the result each
// accepted byte beat should give, and compares every accepted result beat
// field by field with the oldest outstanding one. Reports the running
// failure count and the number of results still owed by the block.
// ----------------------------------------------------------------------------
module obu_parse_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic [obuhp_pkg::LEFT_W-1:0] bytes_after,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [2:0]                   status,
  input  logic [obuhp_pkg::TYPE_W-1:0] obu_type,
  input  logic                         size_present,
  input  logic [obuhp_pkg::SIZE_W-1:0] obu_size,
  output int                           fail_count,
  output int                           pending
);
  import obuhp_pkg::*;

  result_t           hdr_q[$];
  logic              in_size;
  logic [SIZE_W-1:0] accum;
  logic [IDX_W-1:0]  idx;
  logic [TYPE_W-1:0] htype;
  int                errs;
  int                reported;

  initial begin
    fail_count = 0;
    pending    = 0;
    errs       = 0;
    reported   = 0;
  end

  // Advances the parse by one byte; returns 1 when the byte ends a header.
  function automatic bit parse_obu_byte(input logic [7:0] b, input logic [LEFT_W-1:0] left,
                                        output result_t r);
    logic              last;
    logic [SIZE_W-1:0] grp;
    r = '0;
    if (!in_size) begin
      htype          = b[6:3];
      r.obu_type     = b[6:3];
      r.size_present = b[1];
      if (b[7]) begin
        r.status = ST_FORBIDDEN;
      end else if (b[6:3] == '0) begin
        r.status = ST_RESERVED;
      end else if (b[2]) begin
        r.status = ST_EXTENSION;
      end else if (!b[1]) begin
        r.status   = ST_OK;
        r.obu_size = SIZE_W'(left);
      end else if (left == '0) begin
        r.status = ST_TRUNCATED;
      end else begin
        in_size = 1'b1;
        accum   = '0;
        idx     = '0;
        return 1'b0;
      end
    end else begin
      last           = (int'(idx) + 1 >= MAX_SIZE_BYTES) || !b[7];
      grp            = SIZE_W'(b[6:0]);
      accum          = accum | (grp << (int'(idx) * LEB_BITS));
      r.obu_type     = htype;
      r.size_present = 1'b1;
      if (last) begin
        if (accum > SIZE_W'(left)) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.status   = ST_OK;
          r.obu_size = accum;
        end
      end else if (left == '0) begin
        r.status = ST_TRUNCATED;
      end else begin
        idx = idx + 1'b1;
        return 1'b0;
      end
    end
    in_size = 1'b0;
    accum   = '0;
    idx     = '0;
    return 1'b1;
  endfunction

  task automatic flag_result(input string what, input result_t e);
    errs++;
    if (reported < 10) begin
      $display("%t %s: exp st %0d type %0d sp %0d size %0h / got st %0d type %0d sp %0d size %0h",
               $realtime, what, e.status, e.obu_type, e.size_present, e.obu_size,
               status, obu_type, size_present, obu_size);
    end
    reported++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      in_size = 1'b0;
      accum   = '0;
      idx     = '0;
      htype   = '0;
      hdr_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (hdr_q.size() == 0) begin
          flag_result("unexpected result beat", '0);
        end else begin
          e = hdr_q.pop_front();
          if (status !== e.status || obu_type !== e.obu_type ||
              size_present !== e.size_present || obu_size !== e.obu_size) begin
            flag_result("result mismatch", e);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (parse_obu_byte(data_byte, bytes_after, e)) hdr_q.push_back(e);
      end
    end
    fail_count <= errs;
    pending    <= hdr_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for obu_header_parser_core. A directed set of headers
// and size fields covers the error priorities, truncation and the size field
// length limit; then random units, mostly well-formed with random content,
// mixed with broken fields and raw noise. Both sides stall at random, and
// the receiver holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import obuhp_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        data_byte;
  logic [LEFT_W-1:0] bytes_after;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        status;
  logic [TYPE_W-1:0] obu_type;
  logic              size_present;
  logic [SIZE_W-1:0] obu_size;
  int                fail_count;
  int                pending;
  int                beats;
  int                cyc;

  obu_header_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .bytes_after(bytes_after),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .obu_type(obu_type),
    .size_present(size_present), .obu_size(obu_size)
  );

  obu_parse_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .bytes_after(bytes_after),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .obu_type(obu_type),
    .size_present(size_present), .obu_size(obu_size),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[obu_header_parser_core] ERROR");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stretch with none
  initial begin
    out_ready = 1'b0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 600 && cyc < 1000) begin
        out_ready <= 1'b0;
      end else if (cyc >= 1500 && cyc < 1900) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic [LEFT_W-1:0] n);
    while (!(beats >= 1200 && beats < 1500) && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= d;
    bytes_after <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats++;
  endtask

  task automatic send_random_unit();
    int          kind;
    int          len;
    int          minlen;
    int          n;
    logic [63:0] sz;
    logic [31:0] tail;
    logic [7:0]  hdr;
    logic        cont;
    kind = $urandom_range(99);
    hdr  = {1'b0, 4'($urandom_range(15, 1)), 1'b0, 1'b1, 1'($urandom)};
    if (kind < 55) begin
      sz = 64'($urandom) >> $urandom_range(31, 0);
      if (sz > 64'hFFFF_FFE0) sz = 64'hFFFF_FFE0;
      minlen = 1;
      while ((sz >> (7 * minlen)) != 0) minlen++;
      len = ($urandom_range(3) == 0) ? $urandom_range(8, minlen) : minlen;
      case ($urandom_range(3))
        0: tail = sz[31:0] + $urandom_range(20);
        1: tail = (sz != 0) ? sz[31:0] - 1 : '0;
        default: tail = sz[31:0];
      endcase
      send_byte(hdr, tail + len);
      for (int i = 0; i < len; i++) begin
        cont = (i < len - 1) ? 1'b1 : ((len == MAX_SIZE_BYTES) ? 1'($urandom) : 1'b0);
        send_byte({cont, 7'(sz >> (7 * i))}, tail + (len - 1 - i));
      end
    end else if (kind < 65) begin
      n = $urandom_range(6);
      send_byte(hdr, n);
      for (int i = 0; i < n; i++) send_byte({1'b1, 7'($urandom)}, n - 1 - i);
    end else if (kind < 80) begin
      hdr[1] = 1'b0;
      send_byte(hdr, $urandom);
    end else if (kind < 90) begin
      hdr = 8'($urandom);
      case ($urandom_range(2))
        0: hdr[7] = 1'b1;
        1: hdr[6:3] = '0;
        default: hdr[2] = 1'b1;
      endcase
      send_byte(hdr, $urandom);
    end else begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom), $urandom_range(1) ? $urandom : $urandom_range(2 * n));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    bytes_after = '0;
    beats       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header errors and their priority
    send_byte(8'h80, 32'd5);
    send_byte(8'hFF, 32'hFFFF_FFFF);
    send_byte(8'h02, 32'd0);
    send_byte(8'h06, 32'd7);
    send_byte(8'h0C, 32'd3);
    send_byte(8'h0E, 32'd1);
    // no size field
    send_byte(8'h08, 32'd0);
    send_byte(8'h79, 32'hFFFF_FFFF);
    // size flag on the last byte
    send_byte(8'h0A, 32'd0);
    // short size fields: fits, too large, buffer ends with continuation set
    send_byte(8'h12, 32'd3);
    send_byte(8'h02, 32'd2);
    send_byte(8'h12, 32'd5);
    send_byte(8'h85, 32'd4);
    send_byte(8'h00, 32'd3);
    send_byte(8'h7B, 32'd1);
    send_byte(8'h80, 32'd0);
    // size field at its length limit
    send_byte(8'h12, 32'd100);
    for (int i = 0; i < MAX_SIZE_BYTES; i++) send_byte(8'hFF, 32'd99 - i);
    send_byte(8'h7A, 32'd9);
    for (int i = 0; i < MAX_SIZE_BYTES; i++) send_byte(8'h80, 32'd8 - i);

    while (beats < 2000) send_random_unit();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[obu_header_parser_core] OK");
    end else begin
      $display("[obu_header_parser_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/obuhp_pkg.sv
rtl/core/obuhp_step.sv
rtl/core/obu_header_parser_core.sv
tb/obu_parse_checker.sv
tb/tb_top.sv
